@@ rtl/smt_pkg.sv @@
// Types and constants shared by the signature match tracker modules.
package smt_pkg;

    localparam int ENT_W     = 8;
    localparam int SIG_IN_W  = 32;
    localparam int SLOT_OUT_W = 8;
    localparam int CFG_W     = 32;

    // Configuration register indexes.
    localparam logic REG_REQUIRED_MASK = 1'b0;

    typedef enum logic [1:0] {
        ACT_NONE   = 2'd0,
        ACT_ADD    = 2'd1,
        ACT_REMOVE = 2'd2,
        ACT_FULL   = 2'd3
    } action_t;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_LOOKUP,
        ST_MOVE
    } state_t;

    typedef struct packed {
        logic [ENT_W-1:0]    entity_id;
        logic [SIG_IN_W-1:0] entity_signature;
    } in_beat_t;

    typedef struct packed {
        action_t               action;
        logic [SLOT_OUT_W-1:0] slot_index;
        logic [ENT_W-1:0]      moved_entity;
        logic [SLOT_OUT_W-1:0] tracked_count;
    } result_t;

endpackage

@@ rtl/smt_ram.sv @@
// Single-port-write, single-port-read synchronous RAM with registered read data.
module smt_ram #(
    parameter int DEPTH = 256,
    parameter int WIDTH = 8,
    parameter int AW    = 8
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        rdata <= mem[raddr];
    end

endmodule

@@ rtl/smt_ctrl.sv @@
// Sequencer and index maps: lookup, append, swap-remove and the post-reset clear.
module smt_ctrl #(
    parameter int ENTITY_SLOTS   = 256,
    parameter int SIGNATURE_BITS = 32
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    output logic                          busy,
    input  smt_pkg::in_beat_t             item,
    input  logic [smt_pkg::CFG_W-1:0]     required_mask,
    output logic                          done,
    output smt_pkg::result_t              result
);

    localparam int SLOT_W = $clog2(ENTITY_SLOTS);
    localparam int CNT_W  = SLOT_W + 1;
    localparam int CMP_W  = (SIGNATURE_BITS < smt_pkg::SIG_IN_W) ? SIGNATURE_BITS
                                                                  : smt_pkg::SIG_IN_W;
    localparam logic [smt_pkg::SIG_IN_W-1:0] SIG_MASK =
        {smt_pkg::SIG_IN_W{1'b1}} >> (smt_pkg::SIG_IN_W - CMP_W);
    localparam logic [SLOT_W-1:0] LAST_ADDR = SLOT_W'(ENTITY_SLOTS - 1);
    localparam logic [CNT_W-1:0]  SLOTS_CNT = CNT_W'(ENTITY_SLOTS);
    localparam logic [CNT_W-1:0]  ONE_CNT   = CNT_W'(1);

    smt_pkg::state_t state_reg, state_next;

    logic [SLOT_W-1:0]         clr_cnt_reg, clr_cnt_next;
    logic [CNT_W-1:0]          nfs_reg, nfs_next;
    logic [smt_pkg::ENT_W-1:0] ent_reg, ent_next;
    logic                      match_reg, match_next;
    logic                      range_reg, range_next;
    logic [smt_pkg::ENT_W-1:0] mv_ent_reg, mv_ent_next;
    logic [SLOT_W-1:0]         mv_slot_reg, mv_slot_next;
    logic                      done_reg, done_next;
    smt_pkg::result_t          result_reg, result_next;

    // slot_of_entity map
    logic                      soe_we;
    logic [SLOT_W-1:0]         soe_waddr, soe_wdata, soe_raddr, soe_rdata;
    // entity_in_slot map
    logic                      eis_we;
    logic [SLOT_W-1:0]         eis_waddr, eis_raddr;
    logic [smt_pkg::ENT_W-1:0] eis_wdata, eis_rdata;

    logic [SLOT_W-1:0] back;
    logic              cur_zero;
    logic              do_add, do_full, do_rem, do_move;
    logic [CNT_W-1:0]  nfs_after;
    logic              in_range;
    logic [smt_pkg::SIG_IN_W-1:0] req_m;

    smt_ram #(.DEPTH(ENTITY_SLOTS), .WIDTH(SLOT_W), .AW(SLOT_W)) u_slot_of_entity (
        .clk   (clk),
        .we    (soe_we),
        .waddr (soe_waddr),
        .wdata (soe_wdata),
        .raddr (soe_raddr),
        .rdata (soe_rdata)
    );

    smt_ram #(.DEPTH(ENTITY_SLOTS), .WIDTH(smt_pkg::ENT_W), .AW(SLOT_W)) u_entity_in_slot (
        .clk   (clk),
        .we    (eis_we),
        .waddr (eis_waddr),
        .wdata (eis_wdata),
        .raddr (eis_raddr),
        .rdata (eis_rdata)
    );

    assign back      = SLOT_W'(nfs_reg - ONE_CNT);
    assign cur_zero  = (soe_rdata == '0);
    assign do_add    = range_reg && cur_zero && match_reg && (nfs_reg < SLOTS_CNT);
    assign do_full   = range_reg && cur_zero && match_reg && !(nfs_reg < SLOTS_CNT);
    assign do_rem    = range_reg && !cur_zero && !match_reg && (nfs_reg > ONE_CNT);
    // Removing anything but the tail pulls the tail entry into the hole.
    assign do_move   = do_rem && (back != soe_rdata);
    assign in_range  = (int'(item.entity_id) < ENTITY_SLOTS);
    assign req_m     = required_mask & SIG_MASK;

    always_comb
    begin
        nfs_after = nfs_reg;
        if (do_add)
        begin
            nfs_after = nfs_reg + ONE_CNT;
        end
        else if (do_rem)
        begin
            nfs_after = nfs_reg - ONE_CNT;
        end
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            smt_pkg::ST_CLEAR:
            begin
                if (clr_cnt_reg == LAST_ADDR)
                begin
                    state_next = smt_pkg::ST_IDLE;
                end
            end
            smt_pkg::ST_IDLE:
            begin
                if (start)
                begin
                    state_next = smt_pkg::ST_LOOKUP;
                end
            end
            smt_pkg::ST_LOOKUP:
            begin
                state_next = do_move ? smt_pkg::ST_MOVE : smt_pkg::ST_IDLE;
            end
            smt_pkg::ST_MOVE:
            begin
                state_next = smt_pkg::ST_IDLE;
            end
            default:
            begin
                state_next = smt_pkg::ST_CLEAR;
            end
        endcase
    end

    // Datapath and memory control
    always_comb
    begin
        clr_cnt_next = clr_cnt_reg;
        nfs_next     = nfs_reg;
        ent_next     = ent_reg;
        match_next   = match_reg;
        range_next   = range_reg;
        mv_ent_next  = mv_ent_reg;
        mv_slot_next = mv_slot_reg;
        done_next    = 1'b0;
        result_next  = result_reg;
        soe_we       = 1'b0;
        soe_waddr    = SLOT_W'(ent_reg);
        soe_wdata    = '0;
        soe_raddr    = SLOT_W'(item.entity_id);
        eis_we       = 1'b0;
        eis_waddr    = back;
        eis_wdata    = '0;
        eis_raddr    = back;
        busy         = 1'b1;
        case (state_reg)
            smt_pkg::ST_CLEAR:
            begin
                soe_we       = 1'b1;
                soe_waddr    = clr_cnt_reg;
                eis_we       = 1'b1;
                eis_waddr    = clr_cnt_reg;
                clr_cnt_next = clr_cnt_reg + SLOT_W'(1);
            end
            smt_pkg::ST_IDLE:
            begin
                busy = 1'b0;
                if (start)
                begin
                    ent_next   = item.entity_id;
                    range_next = in_range;
                    match_next = ((item.entity_signature & req_m) == req_m);
                end
            end
            smt_pkg::ST_LOOKUP:
            begin
                nfs_next  = nfs_after;
                done_next = 1'b1;
                result_next.action       = smt_pkg::ACT_NONE;
                result_next.slot_index   = range_reg ? smt_pkg::SLOT_OUT_W'(soe_rdata) : '0;
                result_next.moved_entity = '0;
                result_next.tracked_count = smt_pkg::SLOT_OUT_W'(nfs_after - ONE_CNT);
                if (do_add)
                begin
                    soe_we    = 1'b1;
                    soe_wdata = SLOT_W'(nfs_reg);
                    eis_we    = 1'b1;
                    eis_waddr = SLOT_W'(nfs_reg);
                    eis_wdata = ent_reg;
                    result_next.action     = smt_pkg::ACT_ADD;
                    result_next.slot_index = smt_pkg::SLOT_OUT_W'(nfs_reg);
                end
                else if (do_full)
                begin
                    result_next.action     = smt_pkg::ACT_FULL;
                    result_next.slot_index = '0;
                end
                else if (do_rem)
                begin
                    // clear own map entry and the tail slot now, relink the mover next cycle
                    soe_we = 1'b1;
                    eis_we = 1'b1;
                    mv_ent_next  = eis_rdata;
                    mv_slot_next = soe_rdata;
                    result_next.action     = smt_pkg::ACT_REMOVE;
                    result_next.slot_index = '0;
                    if (do_move)
                    begin
                        result_next.moved_entity = eis_rdata;
                    end
                end
            end
            smt_pkg::ST_MOVE:
            begin
                soe_we    = 1'b1;
                soe_waddr = SLOT_W'(mv_ent_reg);
                soe_wdata = mv_slot_reg;
                eis_we    = 1'b1;
                eis_waddr = mv_slot_reg;
                eis_wdata = mv_ent_reg;
            end
            default:
            begin
                busy = 1'b1;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= smt_pkg::ST_CLEAR;
            clr_cnt_reg <= '0;
            nfs_reg     <= ONE_CNT;
            done_reg    <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            clr_cnt_reg <= clr_cnt_next;
            nfs_reg     <= nfs_next;
            done_reg    <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ent_reg     <= ent_next;
        match_reg   <= match_next;
        range_reg   <= range_next;
        mv_ent_reg  <= mv_ent_next;
        mv_slot_reg <= mv_slot_next;
        result_reg  <= result_next;
    end

    assign done   = done_reg;
    assign result = result_reg;

endmodule

@@ rtl/signature_match_tracker_top.sv @@
// Top level of the signature match tracker: register port and tracker core.
//
// Keeps a packed list of entities whose signature holds every bit of
// required_mask, using two index maps held in synchronous RAMs. An update is
// taken when start is high and busy is low; its result beat appears on result
// with done high for exactly one cycle, registered out of the lookup state,
// and the receiver cannot stall it. Each update does the map reads, then the
// decide and write; a removal that pulls the tail entry into the freed slot
// holds busy through an extra move state for the second map write. After
// reset, busy stays high while both maps are swept to zero. The user must
// write required_mask only while the block is idle; the block does not enforce it.
module signature_match_tracker_top #(
    parameter int ENTITY_SLOTS   = 256,
    parameter int SIGNATURE_BITS = 32
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      start,
    output logic                      busy,
    input  smt_pkg::in_beat_t         item,
    output logic                      done,
    output smt_pkg::result_t          result,
    input  logic                      psel,
    input  logic                      penable,
    input  logic                      pwrite,
    input  logic [2:0]                paddr,
    input  logic [smt_pkg::CFG_W-1:0] pwdata,
    output logic [smt_pkg::CFG_W-1:0] prdata,
    output logic                      pready
);

    logic [smt_pkg::CFG_W-1:0] mask_reg, mask_next;
    logic                      reg_hit;

    assign pready  = 1'b1;
    assign reg_hit = (paddr[2] == smt_pkg::REG_REQUIRED_MASK);

    always_comb
    begin
        mask_next = mask_reg;
        if (psel && penable && pwrite && reg_hit)
        begin
            mask_next = pwdata;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mask_reg <= '0;
        end
        else
        begin
            mask_reg <= mask_next;
        end
    end

    assign prdata = reg_hit ? mask_reg : '0;

    smt_ctrl #(
        .ENTITY_SLOTS   (ENTITY_SLOTS),
        .SIGNATURE_BITS (SIGNATURE_BITS)
    ) u_ctrl (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .busy          (busy),
        .item          (item),
        .required_mask (mask_reg),
        .done          (done),
        .result        (result)
    );

endmodule

@@ tb/tb.sv @@
`timescale 1ns / 1ps
// Self-checking testbench for signature_match_tracker_top: directed and random updates.
module tb;

    localparam int ENTITY_SLOTS   = 256;
    localparam int SIGNATURE_BITS = 32;
    localparam int IDLE_LIMIT     = 4000;
    localparam int MAX_REPORTS    = 10;
    localparam logic [2:0] MASK_ADDR  = {smt_pkg::REG_REQUIRED_MASK, 2'b00};
    localparam logic [2:0] SPARE_ADDR = 3'd4;

    logic                      clk     = 1'b0;
    logic                      rst_n   = 1'b0;
    logic                      start   = 1'b0;
    logic                      busy;
    smt_pkg::in_beat_t         item    = '0;
    logic                      done;
    smt_pkg::result_t          result;
    logic                      psel    = 1'b0;
    logic                      penable = 1'b0;
    logic                      pwrite  = 1'b0;
    logic [2:0]                paddr   = '0;
    logic [smt_pkg::CFG_W-1:0] pwdata  = '0;
    logic [smt_pkg::CFG_W-1:0] prdata;
    logic                      pready;

    // shadow copy of the tracker
    logic [smt_pkg::CFG_W-1:0] mask_copy = '0;
    logic [8:0]                slot_of   [ENTITY_SLOTS];
    logic [smt_pkg::ENT_W-1:0] entity_at [ENTITY_SLOTS];
    logic [8:0]                next_slot = 9'd1;

    smt_pkg::in_beat_t update_q[$];
    smt_pkg::result_t  tracked_q[$];
    int       fail_count = 0;
    int       burst_left = 1;
    int       gap_left   = 0;
    int       idle_cycles = 0;

    signature_match_tracker_top #(
        .ENTITY_SLOTS   (ENTITY_SLOTS),
        .SIGNATURE_BITS (SIGNATURE_BITS)
    ) dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .busy    (busy),
        .item    (item),
        .done    (done),
        .result  (result),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    task automatic note_mismatch(input string msg);
        if (fail_count < MAX_REPORTS)
            $display("MISMATCH: %s", msg);
        fail_count++;
    endtask

    function automatic smt_pkg::in_beat_t beat(input logic [smt_pkg::ENT_W-1:0] ent,
                                               input logic [31:0] sig);
        smt_pkg::in_beat_t b;
        b.entity_id        = ent;
        b.entity_signature = sig;
        return b;
    endfunction

    // Apply one update to the shadow lists and return the result it should give.
    function automatic smt_pkg::result_t track_update(input smt_pkg::in_beat_t b);
        smt_pkg::result_t          r;
        logic                      match;
        logic [8:0]                cur;
        logic [8:0]                back;
        logic [smt_pkg::ENT_W-1:0] last;
        r = '0;
        r.action = smt_pkg::ACT_NONE;
        match = (b.entity_signature & mask_copy) == mask_copy;
        cur = slot_of[b.entity_id];
        r.slot_index = cur[7:0];
        if (cur == 0 && match)
        begin
            if (next_slot >= ENTITY_SLOTS)
            begin
                r.action = smt_pkg::ACT_FULL;
            end
            else
            begin
                slot_of[b.entity_id] = next_slot;
                entity_at[next_slot] = b.entity_id;
                r.slot_index = next_slot[7:0];
                next_slot = next_slot + 9'd1;
                r.action = smt_pkg::ACT_ADD;
            end
        end
        else if (cur != 0 && !match && next_slot > 1)
        begin
            back = next_slot - 9'd1;
            last = entity_at[back];
            // tail entry fills the hole unless the hole is the tail
            if (back != cur)
            begin
                entity_at[cur] = last;
                slot_of[last] = cur;
                r.moved_entity = last;
            end
            entity_at[back] = '0;
            slot_of[b.entity_id] = '0;
            next_slot = back;
            r.slot_index = '0;
            r.action = smt_pkg::ACT_REMOVE;
        end
        r.tracked_count = 8'(next_slot - 9'd1);
        return r;
    endfunction

    function automatic logic [31:0] pick_signature(input logic [31:0] m);
        int k;
        int sel;
        sel = $urandom_range(0, 99);
        if (sel < 50)
            return m | $urandom;
        if (sel < 75 && m != 0)
        begin
            do
                k = $urandom_range(0, 31);
            while (!m[k]);
            return ($urandom | m) & ~(32'd1 << k);
        end
        if (sel < 90)
            return $urandom;
        return '0;
    endfunction

    // Driver: bursts of beats with random gaps, predicts on every accepted beat.
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            start <= 1'b0;
            item  <= '0;
        end
        else
        begin
            if (start && !busy)
                tracked_q.push_back(track_update(item));
            if (!(start && busy))
            begin
                if (gap_left != 0)
                begin
                    gap_left--;
                    start <= 1'b0;
                end
                else if (update_q.size() != 0)
                begin
                    item  <= update_q.pop_front();
                    start <= 1'b1;
                    if (burst_left <= 1)
                    begin
                        burst_left = $urandom_range(1, 16);
                        gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
                    end
                    else
                        burst_left--;
                end
                else
                    start <= 1'b0;
            end
        end
    end

    // Monitor: every done beat is checked against the oldest prediction.
    always @(posedge clk)
    begin
        smt_pkg::result_t want;
        if (rst_n && done)
        begin
            if (tracked_q.size() == 0)
                note_mismatch($sformatf(
                    "result with nothing pending: act=%0d slot=%0d mv=%0d cnt=%0d",
                    result.action, result.slot_index, result.moved_entity,
                    result.tracked_count));
            else
            begin
                want = tracked_q.pop_front();
                if (result.action !== want.action || result.slot_index !== want.slot_index ||
                    result.moved_entity !== want.moved_entity ||
                    result.tracked_count !== want.tracked_count)
                    note_mismatch($sformatf(
                        "exp act=%0d slot=%0d mv=%0d cnt=%0d, got act=%0d slot=%0d mv=%0d cnt=%0d",
                        want.action, want.slot_index, want.moved_entity, want.tracked_count,
                        result.action, result.slot_index, result.moved_entity,
                        result.tracked_count));
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((start && !busy) || done || (psel && penable))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("tb failed");
                $finish;
            end
        end
    end

    // sampled mid-cycle so the driver's and monitor's updates have settled
    task automatic wait_idle();
        do
            @(negedge clk);
        while (update_q.size() != 0 || tracked_q.size() != 0 || start || busy);
    endtask

    task automatic apb_write(input logic [2:0] addr, input logic [smt_pkg::CFG_W-1:0] data);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (addr[2] == smt_pkg::REG_REQUIRED_MASK)
            mask_copy = data;
    endtask

    task automatic apb_read_check(input logic [2:0] addr,
                                  input logic [smt_pkg::CFG_W-1:0] want);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= addr;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        if (prdata !== want)
            note_mismatch($sformatf("register read exp %08h got %08h", want, prdata));
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    initial
    begin
        int                        order [ENTITY_SLOTS];
        int                        j;
        int                        tmp;
        int                        ph;
        logic [31:0]               m;
        logic [smt_pkg::ENT_W-1:0] ent;

        for (int i = 0; i < ENTITY_SLOTS; i++)
        begin
            slot_of[i]   = '0;
            entity_at[i] = '0;
        end
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // waits out the map clear after reset
        wait_idle();
        apb_write(MASK_ADDR, '0);
        apb_read_check(MASK_ADDR, '0);

        // zero mask: everything matches, even a destroyed entity
        update_q.push_back(beat(8'h00, 32'h0000_0000));
        update_q.push_back(beat(8'hFF, 32'hFFFF_FFFF));
        update_q.push_back(beat(8'h00, 32'h0000_0000));
        update_q.push_back(beat(8'h80, 32'h5555_5555));
        wait_idle();

        apb_write(MASK_ADDR, 32'hFFFF_FFFF);
        apb_write(SPARE_ADDR, 32'h1234_5678);   // no such register, must be dropped
        apb_read_check(MASK_ADDR, mask_copy);
        update_q.push_back(beat(8'h00, 32'hFFFF_FFFE));   // remove, tail moves in
        update_q.push_back(beat(8'hFF, 32'hFFFF_FFFF));   // still tracked
        update_q.push_back(beat(8'hFF, 32'h0000_0000));   // remove the tail itself
        update_q.push_back(beat(8'h01, 32'h7FFF_FFFF));   // untracked, no match
        update_q.push_back(beat(8'h01, 32'hFFFF_FFFF));
        update_q.push_back(beat(8'h80, 32'hAAAA_AAAA));
        update_q.push_back(beat(8'h01, 32'h0000_0000));
        wait_idle();

        apb_write(MASK_ADDR, 32'h0000_8001);
        update_q.push_back(beat(8'hAA, 32'h0000_8001));
        update_q.push_back(beat(8'h55, 32'h0000_8000));
        update_q.push_back(beat(8'hAA, 32'hFFFF_7FFF));
        wait_idle();

        // fill the list: 255 adds, then a refusal for the entity left out
        apb_write(MASK_ADDR, '0);
        for (int i = 0; i < ENTITY_SLOTS; i++)
            order[i] = i;
        for (int i = ENTITY_SLOTS - 1; i > 0; i--)
        begin
            j = $urandom_range(0, i);
            tmp = order[i];
            order[i] = order[j];
            order[j] = tmp;
        end
        for (int i = 0; i < ENTITY_SLOTS; i++)
            update_q.push_back(beat(order[i][smt_pkg::ENT_W-1:0], $urandom));
        for (int i = 0; i < 8; i++)
            update_q.push_back(beat(smt_pkg::ENT_W'($urandom_range(0, 255)), $urandom));
        wait_idle();

        for (ph = 0; ph < 6; ph++)
        begin
            case (ph)
                0: m = $urandom & $urandom & $urandom;
                1: m = 32'hFFFF_FFFF;
                2: m = 32'd1 << $urandom_range(0, 31);
                3: m = $urandom;
                4: m = '0;
                default: m = $urandom & $urandom;
            endcase
            apb_write(MASK_ADDR, m);
            apb_read_check(MASK_ADDR, m);
            for (int i = 0; i < 120; i++)
            begin
                if ($urandom_range(0, 1) != 0)
                    ent = smt_pkg::ENT_W'($urandom_range(0, 31));
                else
                    ent = smt_pkg::ENT_W'($urandom_range(0, 255));
                update_q.push_back(beat(ent, pick_signature(m)));
            end
            wait_idle();
        end

        repeat (8) @(posedge clk);
        if (tracked_q.size() != 0)
            note_mismatch($sformatf("%0d results never arrived", tracked_q.size()));
        if (fail_count == 0)
            $display("tb passed");
        else
            $display("tb failed");
        $finish;
    end

endmodule

@@ filelist.f @@
rtl/smt_pkg.sv
rtl/smt_ram.sv
rtl/smt_ctrl.sv
rtl/signature_match_tracker_top.sv
tb/tb.sv
